// File: sv/pbpc_pkg.sv
`default_nettype none
package pbpc_pkg;

  localparam int unsigned NumTable = 34;
  localparam int unsigned NumPat   = 35;
  localparam int unsigned SshBit   = 34;
  localparam int unsigned WinLen   = 11;
  localparam int unsigned HistLen  = 10;

  localparam logic [4:0] CLASS_NONE    = 5'd0;
  localparam logic [4:0] CLASS_GENERIC = 5'd1;
  localparam logic [5:0] ENTRY_NONE    = 6'd0;

  // Patterns in lower case, right justified: byte k back sits at bits [8k+7:8k].
  localparam logic [87:0] PAT_TEXT [NumPat] = '{
    88'h6173747261,
    88'h72617370626961_6e,
    88'h7562756e7475,
    88'h64656269616e,
    88'h66726565627364,
    88'h726f73737368,
    88'h6d696b726f74696b,
    88'h666f725f77696e646f7773,
    88'h77696e646f7773,
    88'h64726f7062656172,
    88'h6f70656e777274,
    88'h6f706e73656e7365,
    88'h706673656e7365,
    88'h636973636f,
    88'h726f636b79,
    88'h616c6d616c696e7578,
    88'h616c6d61,
    88'h63656e746f73,
    88'h7268656c,
    88'h72656420686174,
    88'h726564686174,
    88'h2e656c37,
    88'h2e656c38,
    88'h2e656c39,
    88'h6665646f7261,
    88'h73757365,
    88'h67656e746f6f,
    88'h61726368,
    88'h616c70696e65,
    88'h6e69786f73,
    88'h6d616e6a61726f,
    88'h766f6964,
    88'h6f7261636c65,
    88'h616d617a6f6e,
    88'h7373682d
  };

  localparam logic [3:0] PAT_LEN [NumPat] = '{
    4'd5, 4'd8, 4'd6, 4'd6, 4'd7, 4'd6, 4'd8, 4'd11, 4'd7, 4'd8,
    4'd7, 4'd8, 4'd7, 4'd5, 4'd5, 4'd9, 4'd4, 4'd6, 4'd4, 4'd7,
    4'd6, 4'd4, 4'd4, 4'd4, 4'd6, 4'd4, 4'd6, 4'd4, 4'd6, 4'd5,
    4'd7, 4'd4, 4'd6, 4'd6, 4'd4
  };

  localparam logic [4:0] PAT_CLASS [NumTable] = '{
    5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd7,  5'd8,  5'd8,  5'd9,
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd15, 5'd16, 5'd17, 5'd17,
    5'd17, 5'd17, 5'd17, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23,
    5'd24, 5'd25, 5'd26, 5'd27
  };

  typedef struct packed {
    logic              valid;
    logic [NumPat-1:0] hits;
  } pbpc_hits_t;

endpackage
`default_nettype wire

// File: sv/priority_banner_pattern_classifier.sv
`default_nettype none
// Banner pattern classifier.
// Input channel: one text byte per transfer (text_byte_i, end_of_text_i) under
// in_valid_i / in_ready_o. Bytes are folded to lower case and matched against
// a fixed pattern table by parallel window comparators; hit flags are sticky
// for the length of one text. A zero byte stops the search until the end mark.
// Output channel: one transfer per text, on the byte marked last, carrying
// class_code_o and winning_entry_o under out_valid_o / out_ready_i.
// Throughput: one byte per cycle while the queue is not full, including back-to-back texts.
// Path: the front matches and queues the hit vector on the transfer of the last
// byte; the back encodes the queue head into the output register once that
// register is empty or its result is being taken.
// Stall: when the receiver holds off, finished hit vectors wait in a queue of
// QueueDepth entries; in_ready_o drops only once that queue is full.
// Reset: clears history, hit flags, queue and the output valid at once; the
// block is ready for a byte as soon as reset is released.
module priority_banner_pattern_classifier #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [4:0] class_code_o,
  output logic [5:0] winning_entry_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);
  import pbpc_pkg::*;

  pbpc_hits_t push, head;
  logic       queue_full, pop;

  // Front: fold case, match, hold sticky flags, push on the last byte.
  pbpc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .queue_full_i  (queue_full),
    .push_o        (push)
  );

  // Decouple: hold finished hit vectors while the receiver stalls.
  pbpc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (queue_full)
  );

  // Back: priority encode the head vector into the output register.
  pbpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .class_code_o    (class_code_o),
    .winning_entry_o (winning_entry_o)
  );

endmodule
`default_nettype wire

// File: sv/pbpc_front.sv
`default_nettype none
module pbpc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          text_byte_i,
  input  logic                end_of_text_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                queue_full_i,
  output pbpc_pkg::pbpc_hits_t push_o
);
  import pbpc_pkg::*;

  logic [7:0]        hist_q [HistLen];
  logic [7:0]        hist_d [HistLen];
  logic [NumPat-1:0] hits_q, hits_d, hits_final, pat_match;
  logic              stopped_q, stopped_d;
  logic [7:0]        lc_byte;
  logic [7:0]        win [WinLen];
  logic              accept, searching;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    lc_byte = text_byte_i;
    if (text_byte_i inside {[8'h41:8'h5A]}) begin
      lc_byte = text_byte_i + 8'h20;
    end
    win[0] = lc_byte;
    for (int k = 1; k < WinLen; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  // Window comparators, one per pattern, all in parallel.
  always_comb begin
    for (int i = 0; i < NumPat; i++) begin
      pat_match[i] = 1'b1;
      for (int k = 0; k < WinLen; k++) begin
        if ((4'(k) < PAT_LEN[i]) && (win[k] != PAT_TEXT[i][8*k +: 8])) begin
          pat_match[i] = 1'b0;
        end
      end
    end
  end

  assign searching  = !stopped_q && (text_byte_i != 8'h00);
  assign hits_final = searching ? (hits_q | pat_match) : hits_q;

  always_comb begin
    hits_d    = hits_q;
    stopped_d = stopped_q;
    hist_d    = hist_q;
    if (accept) begin
      if (end_of_text_i) begin
        hits_d    = '0;
        stopped_d = 1'b0;
        for (int k = 0; k < HistLen; k++) begin
          hist_d[k] = 8'h00;
        end
      end else if (searching) begin
        hits_d    = hits_final;
        hist_d[0] = lc_byte;
        for (int k = 1; k < HistLen; k++) begin
          hist_d[k] = hist_q[k-1];
        end
      end else if (!stopped_q) begin
        stopped_d = 1'b1;
      end
    end
  end

  assign push_o.valid = accept && end_of_text_i;
  assign push_o.hits  = hits_final;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q    <= '0;
      stopped_q <= 1'b0;
      for (int k = 0; k < HistLen; k++) begin
        hist_q[k] <= 8'h00;
      end
    end else begin
      hits_q    <= hits_d;
      stopped_q <= stopped_d;
      hist_q    <= hist_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/pbpc_queue.sv
`default_nettype none
module pbpc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbpc_pkg::pbpc_hits_t push_i,
  input  logic                 pop_i,
  output pbpc_pkg::pbpc_hits_t head_o,
  output logic                 full_o
);
  import pbpc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [NumPat-1:0] mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.hits  = mem[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.hits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/pbpc_back.sv
`default_nettype none
module pbpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pbpc_pkg::pbpc_hits_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [4:0]           class_code_o,
  output logic [5:0]           winning_entry_o
);
  import pbpc_pkg::*;

  logic       out_valid_q;
  logic [4:0] class_q, class_d;
  logic [5:0] entry_q, entry_d;

  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  // First table entry in table order wins; scan from the back so it lands last.
  always_comb begin
    class_d = CLASS_NONE;
    entry_d = ENTRY_NONE;
    for (int i = NumTable - 1; i >= 0; i--) begin
      if (head_i.hits[i]) begin
        class_d = PAT_CLASS[i];
        entry_d = 6'(i + 1);
      end
    end
    if ((entry_d == ENTRY_NONE) && head_i.hits[SshBit]) begin
      class_d = CLASS_GENERIC;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      class_q <= class_d;
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign class_code_o    = class_q;
  assign winning_entry_o = entry_q;

endmodule
`default_nettype wire

// File: sv/pbpc_checker.sv
`default_nettype none
module pbpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] text_byte_i,
  input logic       end_of_text_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [4:0] class_code_o,
  input logic [5:0] winning_entry_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(class_code_o) && $stable(winning_entry_o))
    else $error("stalled result changed");

  a_entry_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (winning_entry_o != 6'd0) |->
      (class_code_o >= 5'd2) && (class_code_o <= 5'd27) && (winning_entry_o <= 6'd34))
    else $error("table hit with bad class or entry");

  a_no_entry_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (winning_entry_o == 6'd0) |-> (class_code_o <= 5'd1))
    else $error("slug class without a table entry");

  // Hold a waiting byte until its transfer.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=>
      in_valid_i && $stable(text_byte_i) && $stable(end_of_text_i))
    else $error("waiting input byte changed");

endmodule

bind priority_banner_pattern_classifier pbpc_checker u_checker (.*);
`default_nettype wire
